/* hdl/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the box physics table.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int NUM_OBJECTS = 8;
    localparam int IDX_W       = 3;
    localparam int VAL_W       = 20;
    localparam int HALF_W      = 12;
    localparam int SQ_W        = 9;
    localparam int TMR_W       = 4;

    localparam logic [SQ_W-1:0]  SQ_ONE    = 9'd256;
    localparam logic [SQ_W-1:0]  SQ_HIT    = 9'd205;
    localparam logic [6:0]       SQ_EASE   = 7'd51;
    localparam logic [TMR_W-1:0] HIT_TICKS = 4'd10;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         obj_index;
        logic signed [VAL_W-1:0]  pos_x;
        logic signed [VAL_W-1:0]  pos_y;
        logic signed [VAL_W-1:0]  vel_x;
        logic signed [VAL_W-1:0]  vel_y;
        logic signed [VAL_W-1:0]  acc_x;
        logic signed [VAL_W-1:0]  acc_y;
        logic [HALF_W-1:0]        half_w;
        logic [HALF_W-1:0]        half_h;
        logic                     movable;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [VAL_W-1:0]  out_pos_x;
        logic signed [VAL_W-1:0]  out_pos_y;
        logic signed [VAL_W-1:0]  out_vel_x;
        logic signed [VAL_W-1:0]  out_vel_y;
        logic [SQ_W-1:0]          out_squeeze;
        logic                     last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             integrate;
        logic             resolve;
        logic             emit;
        logic [IDX_W-1:0] idx_i;
        logic [IDX_W-1:0] idx_j;
    } dp_cmd_t;

    // clamp a 22 bit signed sum to 20 bits
    function automatic logic signed [VAL_W-1:0] sat20(input logic signed [VAL_W+1:0] v);
        if (v > 22'sd524287)
            return 20'sd524287;
        else if (v < -22'sd524288)
            return -20'sd524288;
        else
            return v[VAL_W-1:0];
    endfunction

endpackage

/* hdl/aabb_collision_physics_step.sv */
// ----------------------------------------------------------------------------
// aabb_collision_physics_step
// Box physics table with axis-aligned collision response.
// ----------------------------------------------------------------------------
// A load transaction writes one entry. A tick runs an integration pass over
// every entry, then the pair checks (one ordered pair per cycle through a
// single compare and push unit, self pairs skipped in place), then an
// ST_EMIT and ST_OUT step per result, advancing while out_stall is low.
// The input stalls from tick acceptance until the last result is taken.
module aabb_collision_physics_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  aabb_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output aabb_pkg::out_item_t out_data
);

    aabb_pkg::dp_cmd_t ctl;

    aabb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    aabb_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .in_item (in_data),
        .res     (out_data)
    );

endmodule

/* hdl/aabb_datapath.sv */
// ----------------------------------------------------------------------------
// aabb_datapath
// Entry table, integration, pair resolution and result register.
// ----------------------------------------------------------------------------
module aabb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  aabb_pkg::dp_cmd_t   ctl,
    input  aabb_pkg::in_item_t  in_item,
    output aabb_pkg::out_item_t res
);

    logic signed [19:0] px_reg [aabb_pkg::NUM_OBJECTS];
    logic signed [19:0] py_reg [aabb_pkg::NUM_OBJECTS];
    logic signed [19:0] vx_reg [aabb_pkg::NUM_OBJECTS];
    logic signed [19:0] vy_reg [aabb_pkg::NUM_OBJECTS];
    logic signed [19:0] ax_reg [aabb_pkg::NUM_OBJECTS];
    logic signed [19:0] ay_reg [aabb_pkg::NUM_OBJECTS];
    logic [11:0]        hw_reg [aabb_pkg::NUM_OBJECTS];
    logic [11:0]        hh_reg [aabb_pkg::NUM_OBJECTS];
    logic               mv_reg [aabb_pkg::NUM_OBJECTS];
    logic [8:0]         sq_reg [aabb_pkg::NUM_OBJECTS];
    logic [3:0]         tm_reg [aabb_pkg::NUM_OBJECTS];

    logic [2:0] i, j;
    assign i = ctl.idx_i;
    assign j = ctl.idx_j;

    // integration of entry i
    logic signed [19:0] nvx, nvy, npx, npy;
    logic [8:0]         gap;
    logic [15:0]        ease;
    assign nvx  = aabb_pkg::sat20(22'(vx_reg[i]) + 22'(ax_reg[i]));
    assign nvy  = aabb_pkg::sat20(22'(vy_reg[i]) + 22'(ay_reg[i]));
    assign npx  = aabb_pkg::sat20(22'(px_reg[i]) + 22'(nvx));
    assign npy  = aabb_pkg::sat20(22'(py_reg[i]) + 22'(nvy));
    assign gap  = aabb_pkg::SQ_ONE - sq_reg[i];
    assign ease = (16'(gap) * 16'(aabb_pkg::SQ_EASE) + 16'd128) >> 8;

    // pair test of i against j
    logic signed [21:0] dx, dy, adx, ady, ox, oy, push;
    logic signed [21:0] ws, hs;
    logic               hit, use_x;
    logic signed [21:0] d_sel, p_sel, v_sel;
    logic signed [22:0] psum;
    logic signed [19:0] np, nv;
    assign dx  = 22'(px_reg[i]) - 22'(px_reg[j]);
    assign dy  = 22'(py_reg[i]) - 22'(py_reg[j]);
    assign adx = dx[21] ? -dx : dx;
    assign ady = dy[21] ? -dy : dy;
    assign ws  = {(22 - 21)'(0), ({1'b0, hw_reg[i]} + {1'b0, hw_reg[j]}), 8'd0};
    assign hs  = {(22 - 21)'(0), ({1'b0, hh_reg[i]} + {1'b0, hh_reg[j]}), 8'd0};
    assign hit = (i != j) && (adx < ws) && (ady < hs);
    assign ox  = ws - adx;
    assign oy  = hs - ady;
    assign use_x = ox < oy;
    assign d_sel = use_x ? dx : dy;
    assign p_sel = use_x ? 22'(px_reg[i]) : 22'(py_reg[i]);
    assign v_sel = use_x ? 22'(vx_reg[i]) : 22'(vy_reg[i]);
    always_comb
    begin
        push = use_x ? ox : oy;
        if (mv_reg[j])
            push = push >>> 1;
        // a full push can exceed the 22 bit range before clamping
        if (d_sel == 22'sd0)
            psum = 23'(p_sel);
        else if (d_sel[21])
            psum = 23'(p_sel) - 23'(push);
        else
            psum = 23'(p_sel) + 23'(push);
        if (psum > 23'sd524287)
            np = 20'sd524287;
        else if (psum < -23'sd524288)
            np = -20'sd524288;
        else
            np = psum[19:0];
        // reverse when approaching
        if ((d_sel > 22'sd0 && v_sel < 22'sd0) || (d_sel < 22'sd0 && v_sel > 22'sd0))
            nv = aabb_pkg::sat20(-v_sel);
        else
            nv = v_sel[19:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < aabb_pkg::NUM_OBJECTS; k++)
            begin
                px_reg[k] <= '0; py_reg[k] <= '0;
                vx_reg[k] <= '0; vy_reg[k] <= '0;
                ax_reg[k] <= '0; ay_reg[k] <= '0;
                hw_reg[k] <= '0; hh_reg[k] <= '0;
                mv_reg[k] <= 1'b0;
                sq_reg[k] <= aabb_pkg::SQ_ONE;
                tm_reg[k] <= '0;
            end
        end
        else if (ctl.load)
        begin
            px_reg[in_item.obj_index] <= in_item.pos_x;
            py_reg[in_item.obj_index] <= in_item.pos_y;
            vx_reg[in_item.obj_index] <= in_item.vel_x;
            vy_reg[in_item.obj_index] <= in_item.vel_y;
            ax_reg[in_item.obj_index] <= in_item.acc_x;
            ay_reg[in_item.obj_index] <= in_item.acc_y;
            hw_reg[in_item.obj_index] <= in_item.half_w;
            hh_reg[in_item.obj_index] <= in_item.half_h;
            mv_reg[in_item.obj_index] <= in_item.movable;
            sq_reg[in_item.obj_index] <= aabb_pkg::SQ_ONE;
            tm_reg[in_item.obj_index] <= '0;
        end
        else if (ctl.integrate && mv_reg[i])
        begin
            vx_reg[i] <= nvx;
            vy_reg[i] <= nvy;
            px_reg[i] <= npx;
            py_reg[i] <= npy;
            if (tm_reg[i] != '0)
            begin
                tm_reg[i] <= tm_reg[i] - 4'd1;
                sq_reg[i] <= sq_reg[i] + ease[8:0];
            end
            else
                sq_reg[i] <= aabb_pkg::SQ_ONE;
        end
        else if (ctl.resolve && mv_reg[i] && hit)
        begin
            if (use_x)
            begin
                px_reg[i] <= np;
                vx_reg[i] <= nv;
            end
            else
            begin
                py_reg[i] <= np;
                vy_reg[i] <= nv;
            end
            sq_reg[i] <= aabb_pkg::SQ_HIT;
            tm_reg[i] <= aabb_pkg::HIT_TICKS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            res.out_index   <= i;
            res.out_pos_x   <= px_reg[i];
            res.out_pos_y   <= py_reg[i];
            res.out_vel_x   <= vx_reg[i];
            res.out_vel_y   <= vy_reg[i];
            res.out_squeeze <= sq_reg[i];
            res.last        <= (i == 3'(aabb_pkg::NUM_OBJECTS - 1));
        end
    end

endmodule

/* hdl/aabb_ctrl.sv */
// ----------------------------------------------------------------------------
// aabb_ctrl
// Sequencer for load, integration, pair sweep and result output.
// ----------------------------------------------------------------------------
module aabb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output aabb_pkg::dp_cmd_t ctl
);

    typedef enum logic [2:0] {ST_IDLE, ST_INT, ST_RES, ST_EMIT, ST_OUT} state_t;

    state_t     state_reg;
    logic [2:0] i_reg, j_reg;
    logic       ov_reg;
    logic       accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;

    always_comb
    begin
        ctl.load      = accept && (in_cmd == aabb_pkg::CMD_LOAD);
        ctl.integrate = (state_reg == ST_INT);
        ctl.resolve   = (state_reg == ST_RES);
        ctl.emit      = (state_reg == ST_EMIT);
        ctl.idx_i     = i_reg;
        ctl.idx_j     = j_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    if (accept && in_cmd == aabb_pkg::CMD_TICK)
                        state_reg <= ST_INT;
                end
                ST_INT:
                begin
                    i_reg <= i_reg + 3'd1;
                    if (i_reg == 3'(aabb_pkg::NUM_OBJECTS - 1))
                        state_reg <= ST_RES;
                end
                ST_RES:
                begin
                    j_reg <= j_reg + 3'd1;
                    if (j_reg == 3'(aabb_pkg::NUM_OBJECTS - 1))
                    begin
                        i_reg <= i_reg + 3'd1;
                        if (i_reg == 3'(aabb_pkg::NUM_OBJECTS - 1))
                            state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        ov_reg <= 1'b0;
                        i_reg  <= i_reg + 3'd1;
                        if (i_reg == 3'(aabb_pkg::NUM_OBJECTS - 1))
                            state_reg <= ST_IDLE;
                        else
                            state_reg <= ST_EMIT;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
